// ----- rtl/wlpm_pkg.sv -----
// wlpm_pkg: shared widths, codes, request and result structs and ramp breakpoint table
// for the window/level pseudocolor mapper; no dependencies
`timescale 1ns / 1ps

package wlpm_pkg;

  localparam int LUT_ENTRIES = 4096;
  localparam int LUT_AW      = $clog2(LUT_ENTRIES);
  localparam int PAL_ENTRIES = 256;
  localparam int unsigned PAL_MAX = PAL_ENTRIES - 1;
  localparam int PAL_W       = 8;
  localparam int PIX_W       = 16;
  localparam int COMP_W      = 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 16;
  localparam int MODE_W      = 3;
  localparam int NUM_W       = PIX_W + LUT_AW;
  localparam int unsigned RAMP_SCALE = 1000;
  localparam int RAMP_W      = $clog2(PAL_MAX * RAMP_SCALE + 1);
  localparam int RNUM_W      = RAMP_W + COMP_W;
  localparam int NUM_COMP    = 3;

  typedef enum logic {
    CMD_MAP   = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_REQ_LOW   = 3'd0,
    REG_REQ_HIGH  = 3'd1,
    REG_IMG_MIN   = 3'd2,
    REG_IMG_MAX   = 3'd3,
    REG_MODE      = 3'd4,
    REG_RED_LIM   = 3'd5,
    REG_GREEN_LIM = 3'd6,
    REG_BLUE_LIM  = 3'd7
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRAY   = 3'd0,
    MODE_HALPHA = 3'd1,
    MODE_ORANGE = 3'd2,
    MODE_GREEN  = 3'd3,
    MODE_BLUE   = 3'd4,
    MODE_NULL   = 3'd5
  } mode_t;

  // break fractions in thousandths: [mode][component]
  localparam int unsigned RAMP_LO [5][3] = '{
    '{0, 0, 0}, '{0, 470, 294}, '{0, 156, 509}, '{150, 0, 200}, '{200, 150, 0}
  };
  localparam int unsigned RAMP_HI [5][3] = '{
    '{1000, 1000, 1000}, '{666, 1000, 1000}, '{590, 784, 1000},
    '{980, 1000, 950}, '{980, 950, 1000}
  };

  typedef struct packed {
    logic              active;
    logic [RAMP_W-1:0] lo_p;
    logic [RAMP_W-1:0] hi_p;
    logic [RAMP_W-1:0] den;
  } ramp_brk_t;

  // gamma table access handed from the index pipeline to the table stage
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [LUT_AW-1:0] waddr;
    logic [PAL_W-1:0]  wdata;
    logic [LUT_AW-1:0] lidx;
  } lut_req_t;

  typedef struct packed {
    logic              vld;
    logic [PAL_W-1:0]  palette_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } col_res_t;

  function automatic ramp_brk_t ramp_brk(input logic [MODE_W-1:0] mode,
                                         input logic [1:0] comp);
    ramp_brk_t b;
    int unsigned lo;
    int unsigned hi;
    b  = '0;
    lo = 0;
    hi = 0;
    if (mode <= MODE_W'(MODE_BLUE) && comp <= 2'd2) begin
      lo       = RAMP_LO[mode][comp];
      hi       = RAMP_HI[mode][comp];
      b.active = 1'b1;
    end
    b.lo_p = RAMP_W'(PAL_MAX * lo);
    b.hi_p = RAMP_W'(PAL_MAX * hi);
    b.den  = b.hi_p - b.lo_p;
    return b;
  endfunction

endpackage

// ----- rtl/wlpm_if.sv -----
// wlpm_in_if / wlpm_out_if: valid/ready item channels of the pseudocolor mapper
// depends on wlpm_pkg
`timescale 1ns / 1ps

interface wlpm_in_if import wlpm_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [PIX_W-1:0]  pixel_value;
  logic [LUT_AW-1:0] lut_index;
  logic [PAL_W-1:0]  lut_value;

  modport source(output valid, command, pixel_value, lut_index, lut_value, input ready);
  modport sink(input valid, command, pixel_value, lut_index, lut_value, output ready);
  modport monitor(input valid, ready, command, pixel_value, lut_index, lut_value);
endinterface

interface wlpm_out_if import wlpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAL_W-1:0]  palette_index;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source(output valid, palette_index, red, green, blue, input ready);
  modport sink(input valid, palette_index, red, green, blue, output ready);
  modport monitor(input valid, ready, palette_index, red, green, blue);
endinterface

// ----- rtl/window_level_pseudocolor_map.sv -----
// window_level_pseudocolor_map: top level with configuration registers,
// gamma table memory and output register; depends on wlpm_pkg, wlpm_if,
// wlpm_index and wlpm_color
`timescale 1ns / 1ps

//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------------
//  in_ch     | in  | valid / ready | command, pixel_value, lut_index, lut_value
//  out_ch    | out | valid / ready | palette_index, red, green, blue
//  cfg_*     | in  | cfg_we        | cfg_idx, cfg_wdata
//
// one item per clock sustained while the output is not blocked; a map item
// passes window scaling (the address quotient, one bit per stage), one gamma
// table read and the color ramps (the ramp quotient, one bit per stage);
// it then waits in the output register
// gamma table writes go down the same pipe and land at the table stage, so
// reads and writes keep item order; writes give no result
// the whole pipe stalls only when a result sits unread in the output register
// and another one is ready behind it; bubbles still drain into that gap
// reset is synchronous; the gamma table holds no reset, so load it before use

module window_level_pseudocolor_map import wlpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wlpm_in_if.sink           in_ch,
  wlpm_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // configuration registers
  logic [PIX_W-1:0]  req_low_r;
  logic [PIX_W-1:0]  req_high_r;
  logic [PIX_W-1:0]  img_min_r;
  logic [PIX_W-1:0]  img_max_r;
  logic [MODE_W-1:0] mode_r;
  logic [COMP_W-1:0] red_lim_r;
  logic [COMP_W-1:0] green_lim_r;
  logic [COMP_W-1:0] blue_lim_r;

  // pipe control
  logic     adv;
  lut_req_t req;
  col_res_t res;

  // gamma table stage
  logic [PAL_W-1:0] gamma_mem [LUT_ENTRIES];
  logic [PAL_W-1:0] rd_data_r;
  logic             rd_v_r;

  // output register
  logic              out_v_r, out_v_nxt;
  logic [PAL_W-1:0]  out_pidx_r;
  logic [COMP_W-1:0] out_red_r;
  logic [COMP_W-1:0] out_green_r;
  logic [COMP_W-1:0] out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_low_r   <= '0;
      req_high_r  <= '0;
      img_min_r   <= '0;
      img_max_r   <= '0;
      mode_r      <= MODE_W'(MODE_GRAY);
      red_lim_r   <= '1;
      green_lim_r <= '1;
      blue_lim_r  <= '1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_REQ_LOW:   req_low_r   <= cfg_wdata[PIX_W-1:0];
        REG_REQ_HIGH:  req_high_r  <= cfg_wdata[PIX_W-1:0];
        REG_IMG_MIN:   img_min_r   <= cfg_wdata[PIX_W-1:0];
        REG_IMG_MAX:   img_max_r   <= cfg_wdata[PIX_W-1:0];
        REG_MODE:      mode_r      <= cfg_wdata[MODE_W-1:0];
        REG_RED_LIM:   red_lim_r   <= cfg_wdata[COMP_W-1:0];
        REG_GREEN_LIM: green_lim_r <= cfg_wdata[COMP_W-1:0];
        REG_BLUE_LIM:  blue_lim_r  <= cfg_wdata[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe moves unless a finished result would overwrite an unread one
  assign adv         = !out_v_r || out_ch.ready || !res.vld;
  assign in_ch.ready = adv;

  wlpm_index u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_ch.valid),
    .in_cmd   (in_ch.command),
    .in_pix   (in_ch.pixel_value),
    .in_addr  (in_ch.lut_index),
    .in_val   (in_ch.lut_value),
    .req_low  (req_low_r),
    .req_high (req_high_r),
    .img_min  (img_min_r),
    .img_max  (img_max_r),
    .req      (req)
  );

  // single-port table: each stage slot carries either a write or a read
  always_ff @(posedge clk) begin
    if (adv && req.vld) begin
      if (req.cmd == CMD_WRITE) begin
        gamma_mem[req.waddr] <= req.wdata;
      end else begin
        rd_data_r <= gamma_mem[req.lidx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (adv) begin
      rd_v_r <= req.vld && req.cmd == CMD_MAP;
    end
  end

  wlpm_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .rd_vld    (rd_v_r),
    .rd_data   (rd_data_r),
    .mode      (mode_r),
    .red_lim   (red_lim_r),
    .green_lim (green_lim_r),
    .blue_lim  (blue_lim_r),
    .res       (res)
  );

  always_comb begin
    priority if (adv && res.vld) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_pidx_r  <= res.palette_index;
      out_red_r   <= res.red;
      out_green_r <= res.green;
      out_blue_r  <= res.blue;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.palette_index = out_pidx_r;
  assign out_ch.red           = out_red_r;
  assign out_ch.green         = out_green_r;
  assign out_ch.blue          = out_blue_r;

`ifndef ASSERT_OFF
  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // a full output register with a result behind it must hold off the input
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready && res.vld) |-> !in_ch.ready)
    else $error("input taken while pipe is blocked");

  // a map item leaving the index pipe always reads the table
  a_map_read: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req.vld && req.cmd == CMD_MAP) |=> rd_v_r)
    else $error("map item lost at table stage");

  // a finished result is always captured in the output register
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.vld) |=> out_ch.valid)
    else $error("result dropped at output");
`endif

endmodule

// ----- rtl/wlpm_index.sv -----
// wlpm_index: window selection and pipelined scaling of a pixel to a gamma
// table address, one quotient bit per stage; depends on wlpm_pkg
`timescale 1ns / 1ps

module wlpm_index import wlpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  cmd_t              in_cmd,
  input  logic [PIX_W-1:0]  in_pix,
  input  logic [LUT_AW-1:0] in_addr,
  input  logic [PAL_W-1:0]  in_val,
  input  logic [PIX_W-1:0]  req_low,
  input  logic [PIX_W-1:0]  req_high,
  input  logic [PIX_W-1:0]  img_min,
  input  logic [PIX_W-1:0]  img_max,
  output lut_req_t          req
);

  typedef struct packed {
    cmd_t              cmd;
    logic [LUT_AW-1:0] addr;
    logic [PAL_W-1:0]  val;
    logic              below;
    logic              above;
    logic              eq;
  } ictl_t;

  logic [PIX_W-1:0] win_low_r, win_low_nxt;
  logic [PIX_W-1:0] win_high_r, win_high_nxt;
  logic [PIX_W-1:0] win_den_r;

  logic              e_v_r;
  cmd_t              e_cmd_r;
  logic [PIX_W-1:0]  e_pix_r;
  logic [LUT_AW-1:0] e_addr_r;
  logic [PAL_W-1:0]  e_val_r;

  logic             f_v_r;
  ictl_t            f_ctl_r;
  logic [PIX_W-1:0] f_diff_r;

  logic [LUT_AW:0]   dv_r;
  ictl_t             ctl_r [LUT_AW+1];
  logic [NUM_W-1:0]  rem_r [LUT_AW+1];
  logic [LUT_AW-1:0] q_r   [LUT_AW+1];
  logic [NUM_W-1:0]  rem_nxt [LUT_AW];
  logic [LUT_AW-1:0] q_nxt   [LUT_AW];

  // window bounds follow the registers, so they settle while the block is idle
  always_comb begin
    if (req_low == '0 && req_high == '0) begin
      win_low_nxt  = img_min;
      win_high_nxt = img_max;
    end else begin
      win_low_nxt  = (req_low >= img_min && req_low <= img_max) ? req_low : img_min;
      win_high_nxt = (req_high >= img_min && req_high <= img_max) ? req_high : img_max;
    end
  end

  always_ff @(posedge clk) begin
    win_low_r  <= win_low_nxt;
    win_high_r <= win_high_nxt;
    win_den_r  <= win_high_r - win_low_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      dv_r  <= '0;
    end else if (adv) begin
      e_v_r <= in_vld;
      f_v_r <= e_v_r;
      dv_r  <= {dv_r[LUT_AW-1:0], f_v_r};
    end
  end

  always_comb begin
    logic [NUM_W-1:0] trial;
    for (int s = 0; s < LUT_AW; s++) begin
      trial = NUM_W'(win_den_r) << (LUT_AW - 1 - s);
      if (rem_r[s] >= trial) begin
        rem_nxt[s] = rem_r[s] - trial;
        q_nxt[s]   = (q_r[s] << 1) | LUT_AW'(1);
      end else begin
        rem_nxt[s] = rem_r[s];
        q_nxt[s]   = q_r[s] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_cmd_r  <= in_cmd;
      e_pix_r  <= in_pix;
      e_addr_r <= in_addr;
      e_val_r  <= in_val;

      f_ctl_r.cmd   <= e_cmd_r;
      f_ctl_r.addr  <= e_addr_r;
      f_ctl_r.val   <= e_val_r;
      f_ctl_r.below <= e_pix_r < win_low_r;
      f_ctl_r.above <= e_pix_r > win_high_r;
      f_ctl_r.eq    <= win_high_r == win_low_r;
      f_diff_r      <= e_pix_r - win_low_r;

      // times (LUT_ENTRIES-1) as a shift and subtract
      ctl_r[0] <= f_ctl_r;
      rem_r[0] <= {f_diff_r, {LUT_AW{1'b0}}} - NUM_W'(f_diff_r);
      q_r[0]   <= '0;
      for (int s = 0; s < LUT_AW; s++) begin
        ctl_r[s+1] <= ctl_r[s];
        rem_r[s+1] <= rem_nxt[s];
        q_r[s+1]   <= q_nxt[s];
      end
    end
  end

  always_comb begin
    req.vld   = dv_r[LUT_AW];
    req.cmd   = ctl_r[LUT_AW].cmd;
    req.waddr = ctl_r[LUT_AW].addr;
    req.wdata = ctl_r[LUT_AW].val;
    priority if (ctl_r[LUT_AW].below) begin
      req.lidx = '0;
    end else if (ctl_r[LUT_AW].above) begin
      req.lidx = LUT_AW'(LUT_ENTRIES - 1);
    end else if (ctl_r[LUT_AW].eq) begin
      req.lidx = '0;
    end else begin
      req.lidx = q_r[LUT_AW];
    end
  end

endmodule

// ----- rtl/wlpm_color.sv -----
// wlpm_color: palette index to red, green and blue through per-mode ramps,
// pipelined with one quotient bit per stage; depends on wlpm_pkg
`timescale 1ns / 1ps

module wlpm_color import wlpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              rd_vld,
  input  logic [PAL_W-1:0]  rd_data,
  input  logic [MODE_W-1:0] mode,
  input  logic [COMP_W-1:0] red_lim,
  input  logic [COMP_W-1:0] green_lim,
  input  logic [COMP_W-1:0] blue_lim,
  output col_res_t          res
);

  ramp_brk_t         brk [NUM_COMP];
  logic [COMP_W-1:0] lim [NUM_COMP];
  logic [PAL_W-1:0]  pidx_sat;

  logic              c0_v_r;
  logic [PAL_W-1:0]  c0_pidx_r;
  logic [RAMP_W-1:0] c0_scaled_r;

  logic              c1_v_r;
  logic [PAL_W-1:0]  c1_pidx_r;
  logic              c1_lt_r   [NUM_COMP];
  logic              c1_gt_r   [NUM_COMP];
  logic [RAMP_W-1:0] c1_diff_r [NUM_COMP];

  logic [COMP_W:0]   dv_r;
  logic [PAL_W-1:0]  pidx_r [COMP_W+1];
  logic              lt_r   [NUM_COMP][COMP_W+1];
  logic              gt_r   [NUM_COMP][COMP_W+1];
  logic [RNUM_W-1:0] rem_r  [NUM_COMP][COMP_W+1];
  logic [COMP_W-1:0] q_r    [NUM_COMP][COMP_W+1];
  logic [RNUM_W-1:0] rem_nxt [NUM_COMP][COMP_W];
  logic [COMP_W-1:0] q_nxt   [NUM_COMP][COMP_W];
  logic [COMP_W-1:0] comp_val [NUM_COMP];

  always_comb begin
    lim[0] = red_lim;
    lim[1] = green_lim;
    lim[2] = blue_lim;
    for (int c = 0; c < NUM_COMP; c++) begin
      brk[c] = ramp_brk(mode, 2'(c));
    end
    pidx_sat = (PAL_W'(PAL_MAX) < rd_data) ? PAL_W'(PAL_MAX) : rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_v_r <= 1'b0;
      c1_v_r <= 1'b0;
      dv_r   <= '0;
    end else if (adv) begin
      c0_v_r <= rd_vld;
      c1_v_r <= c0_v_r;
      dv_r   <= {dv_r[COMP_W-1:0], c1_v_r};
    end
  end

  always_comb begin
    logic [RNUM_W-1:0] trial;
    for (int c = 0; c < NUM_COMP; c++) begin
      for (int s = 0; s < COMP_W; s++) begin
        trial = RNUM_W'(brk[c].den) << (COMP_W - 1 - s);
        if (rem_r[c][s] >= trial) begin
          rem_nxt[c][s] = rem_r[c][s] - trial;
          q_nxt[c][s]   = (q_r[c][s] << 1) | COMP_W'(1);
        end else begin
          rem_nxt[c][s] = rem_r[c][s];
          q_nxt[c][s]   = q_r[c][s] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_pidx_r   <= pidx_sat;
      c0_scaled_r <= RAMP_W'(pidx_sat) * RAMP_W'(RAMP_SCALE);

      c1_pidx_r <= c0_pidx_r;
      for (int c = 0; c < NUM_COMP; c++) begin
        c1_lt_r[c]   <= c0_scaled_r < brk[c].lo_p;
        c1_gt_r[c]   <= c0_scaled_r > brk[c].hi_p;
        c1_diff_r[c] <= c0_scaled_r - brk[c].lo_p;
      end

      pidx_r[0] <= c1_pidx_r;
      for (int s = 0; s < COMP_W; s++) begin
        pidx_r[s+1] <= pidx_r[s];
      end
      for (int c = 0; c < NUM_COMP; c++) begin
        lt_r[c][0]  <= c1_lt_r[c];
        gt_r[c][0]  <= c1_gt_r[c];
        rem_r[c][0] <= RNUM_W'(c1_diff_r[c]) * RNUM_W'(lim[c]);
        q_r[c][0]   <= '0;
        for (int s = 0; s < COMP_W; s++) begin
          lt_r[c][s+1]  <= lt_r[c][s];
          gt_r[c][s+1]  <= gt_r[c][s];
          rem_r[c][s+1] <= rem_nxt[c][s];
          q_r[c][s+1]   <= q_nxt[c][s];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      priority if (!brk[c].active || lt_r[c][COMP_W]) begin
        comp_val[c] = '0;
      end else if (gt_r[c][COMP_W]) begin
        comp_val[c] = lim[c];
      end else if (brk[c].den == '0) begin
        comp_val[c] = '0;
      end else begin
        comp_val[c] = q_r[c][COMP_W];
      end
    end
    res.vld           = dv_r[COMP_W];
    res.palette_index = pidx_r[COMP_W];
    res.red           = comp_val[0];
    res.green         = comp_val[1];
    res.blue          = comp_val[2];
  end

endmodule
